// ===== rtl/core/segment_intersection_assert.svh =====
// Assertion macros for the segment intersection RTL.
`ifndef SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_INTERSECTION_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segment_intersection assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segment_intersection assertion failed");

`endif

// ===== rtl/core/si_pkg.sv =====
// Shared constants for the segment intersection pipeline.
package si_pkg;

  // Q16.16 quotient format used for both line parameters.
  localparam int Q_W    = 32;
  localparam int Q_FRAC = 16;
  // Quotient bits produced by the divider before saturation.
  localparam int Q_BITS = Q_W + 1;

  localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  // Coordinate slots inside the packed coordinate vector.
  localparam int CI_A_START_X = 0;
  localparam int CI_A_START_Y = 1;
  localparam int CI_A_END_X   = 2;
  localparam int CI_A_END_Y   = 3;
  localparam int CI_B_START_X = 4;
  localparam int CI_B_START_Y = 5;
  localparam int CI_B_END_X   = 6;
  localparam int CI_B_END_Y   = 7;
  localparam int NUM_COORDS   = 8;

endpackage

// ===== rtl/core/si_div.sv =====
// Pipelined restoring divider giving a saturated Q16.16 quotient.
module si_div #(
  parameter int NUM_W = 17,
  parameter int SB_W  = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [NUM_W-1:0]              num_mag,
  input  logic [NUM_W-1:0]              den_mag,
  input  logic                          neg,
  input  logic [SB_W-1:0]               in_sb,
  output logic                          out_valid,
  output logic signed [si_pkg::Q_W-1:0] quo,
  output logic [SB_W-1:0]               out_sb
);
  import si_pkg::*;

  localparam int RW  = NUM_W + Q_FRAC;
  localparam int NST = Q_BITS;

  logic [RW-1:0]     rem_r [0:NST];
  logic [NUM_W-1:0]  den_r [0:NST];
  logic [Q_BITS-1:0] quo_r [0:NST];
  logic              neg_r [0:NST];
  logic              ovf_r [0:NST];
  logic              vld_r [0:NST];
  logic [SB_W-1:0]   sb_r  [0:NST];

  logic              vld_o_r;
  logic [Q_W-1:0]    quo_o_r;
  logic [SB_W-1:0]   sb_o_r;
  logic [Q_W-1:0]    quo_nxt;
  logic              big_pos;
  logic              big_neg;

  // Entry stage: scale the dividend and flag quotients of 2^33 or more.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {num_mag, {Q_FRAC{1'b0}}};
      den_r[0] <= den_mag;
      quo_r[0] <= '0;
      neg_r[0] <= neg;
      ovf_r[0] <= (num_mag >> (Q_BITS - Q_FRAC)) >= den_mag;
      sb_r[0]  <= in_sb;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar k = 0; k < NST; k++) begin : g_step
    localparam int SH = NST - 1 - k;
    logic          ge;
    logic [RW-1:0] sub_w;

    assign ge    = (rem_r[k] >> SH) >= RW'(den_r[k]);
    assign sub_w = rem_r[k] - (RW'(den_r[k]) << SH);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? sub_w : rem_r[k];
        quo_r[k+1] <= {quo_r[k][Q_BITS-2:0], ge};
        den_r[k+1] <= den_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
        sb_r[k+1]  <= sb_r[k];
      end
    end
  end

  assign big_pos = ovf_r[NST] || quo_r[NST][Q_BITS-1] || quo_r[NST][Q_W-1];
  assign big_neg = ovf_r[NST] || quo_r[NST][Q_BITS-1] ||
                   (quo_r[NST][Q_W-1] && (|quo_r[NST][Q_W-2:0]));

  always_comb begin
    if (neg_r[NST]) begin
      quo_nxt = big_neg ? Q_MIN : (Q_W'(0) - quo_r[NST][Q_W-1:0]);
    end else begin
      quo_nxt = big_pos ? Q_MAX : quo_r[NST][Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else if (en) begin
      vld_o_r <= vld_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_o_r <= quo_nxt;
      sb_o_r  <= sb_r[NST];
    end
  end

  assign out_valid = vld_o_r;
  assign quo       = $signed(quo_o_r);
  assign out_sb    = sb_o_r;

endmodule

// ===== rtl/core/si_point.sv =====
// Crossing point, extent test and saturation stages of the pipeline.
module si_point #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [si_pkg::Q_W-1:0] n_in,
  input  logic                          meet_in,
  input  logic [8*COORD_WIDTH-1:0]      crd_in,
  output logic                          out_valid,
  output logic                          lines_meet,
  output logic                          hit,
  output logic signed [COORD_WIDTH-1:0] point_x,
  output logic signed [COORD_WIDTH-1:0] point_y
);
  import si_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int D   = W + 1;
  localparam int PW  = D + Q_W;
  localparam int TW  = PW - Q_FRAC;
  localparam int PXW = D + Q_FRAC + 1;
  localparam logic signed [PXW-1:0] SAT_HI = PXW'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [PXW-1:0] SAT_LO = PXW'(-(64'sd1 <<< (W - 1)));

  function automatic logic signed [W-1:0] crd_f(input logic [8*W-1:0] v, input int idx);
    crd_f = $signed(v[idx*W +: W]);
  endfunction

  function automatic logic within_f(input logic signed [PXW-1:0] e1,
                                    input logic signed [PXW-1:0] e2,
                                    input logic signed [PXW-1:0] v);
    logic signed [PXW-1:0] lo;
    logic signed [PXW-1:0] hi;
    lo = (e1 <= e2) ? e1 : e2;
    hi = (e1 <= e2) ? e2 : e1;
    within_f = (lo <= v) && (v <= hi);
  endfunction

  function automatic logic signed [PW-Q_FRAC-1:0] drop_f(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] adj;
    adj = p + (p[PW-1] ? PW'((64'sd1 <<< Q_FRAC) - 64'sd1) : PW'(0));
    drop_f = adj[PW-1:Q_FRAC];
  endfunction

  function automatic logic signed [W-1:0] sat_f(input logic signed [PXW-1:0] v);
    if (v > SAT_HI) begin
      sat_f = SAT_HI[W-1:0];
    end else if (v < SAT_LO) begin
      sat_f = SAT_LO[W-1:0];
    end else begin
      sat_f = v[W-1:0];
    end
  endfunction

  // Stage A: direction of B times the parameter n.
  logic                  pa_vld_r;
  logic                  pa_meet_r;
  logic [8*W-1:0]        pa_crd_r;
  logic signed [PW-1:0]  pa_px_r;
  logic signed [PW-1:0]  pa_py_r;
  logic signed [D-1:0]   ddx;
  logic signed [D-1:0]   ddy;

  // Stage B: full-precision crossing point.
  logic                  pb_vld_r;
  logic                  pb_meet_r;
  logic [8*W-1:0]        pb_crd_r;
  logic signed [PXW-1:0] pb_px_r;
  logic signed [PXW-1:0] pb_py_r;
  logic signed [PXW-1:0] px_nxt;
  logic signed [PXW-1:0] py_nxt;

  // Stage C: result register.
  logic                  pc_vld_r;
  logic                  pc_meet_r;
  logic                  pc_hit_r;
  logic signed [W-1:0]   pc_px_r;
  logic signed [W-1:0]   pc_py_r;
  logic                  hit_nxt;

  assign ddx = D'(crd_f(crd_in, CI_B_END_X)) - D'(crd_f(crd_in, CI_B_START_X));
  assign ddy = D'(crd_f(crd_in, CI_B_END_Y)) - D'(crd_f(crd_in, CI_B_START_Y));

  assign px_nxt = PXW'(crd_f(pa_crd_r, CI_B_START_X)) + PXW'(drop_f(pa_px_r));
  assign py_nxt = PXW'(crd_f(pa_crd_r, CI_B_START_Y)) + PXW'(drop_f(pa_py_r));

  assign hit_nxt =
    within_f(PXW'(crd_f(pb_crd_r, CI_A_START_X)), PXW'(crd_f(pb_crd_r, CI_A_END_X)), pb_px_r) &&
    within_f(PXW'(crd_f(pb_crd_r, CI_A_START_Y)), PXW'(crd_f(pb_crd_r, CI_A_END_Y)), pb_py_r) &&
    within_f(PXW'(crd_f(pb_crd_r, CI_B_START_X)), PXW'(crd_f(pb_crd_r, CI_B_END_X)), pb_px_r) &&
    within_f(PXW'(crd_f(pb_crd_r, CI_B_START_Y)), PXW'(crd_f(pb_crd_r, CI_B_END_Y)), pb_py_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r <= 1'b0;
      pb_vld_r <= 1'b0;
      pc_vld_r <= 1'b0;
    end else if (en) begin
      pa_vld_r <= in_valid;
      pb_vld_r <= pa_vld_r;
      pc_vld_r <= pb_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa_meet_r <= meet_in;
      pa_crd_r  <= crd_in;
      pa_px_r   <= PW'(ddx) * PW'(n_in);
      pa_py_r   <= PW'(ddy) * PW'(n_in);
      pb_meet_r <= pa_meet_r;
      pb_crd_r  <= pa_crd_r;
      pb_px_r   <= px_nxt;
      pb_py_r   <= py_nxt;
      pc_meet_r <= pb_meet_r;
      pc_hit_r  <= pb_meet_r && hit_nxt;
      pc_px_r   <= pb_meet_r ? sat_f(pb_px_r) : W'(0);
      pc_py_r   <= pb_meet_r ? sat_f(pb_py_r) : W'(0);
    end
  end

  assign out_valid  = pc_vld_r;
  assign lines_meet = pc_meet_r;
  assign hit        = pc_hit_r;
  assign point_x    = pc_px_r;
  assign point_y    = pc_py_r;

endmodule

// ===== rtl/core/segment_intersection.sv =====
// Top level of the pipelined 2D segment intersection block.
//
// Takes one pair of segments per transaction and returns one result per pair, in order. Every
// item passes through a fixed pipeline of 76 register stages: an input stage, a 35-stage divider
// for the slope ratio q of segment A, two stages that form the numerator and denominator of the
// line parameter n, a second 35-stage divider for n, and three stages that compute the crossing
// point, test it against both segments' extents and saturate it. The dividers retire one
// quotient bit per stage, which sets the latency; a new transaction is taken every cycle while
// the result side does not stall. When it stalls, the whole pipeline holds, so nothing is lost
// or repeated, and in_tready follows out_tready directly whenever a result is waiting.
// Coordinates are signed fixed point; the fraction scale cancels in every quotient, so results
// share the input format. When the carrier lines are parallel or degenerate, lines_meet, hit and
// both point fields are zero. The extent test uses the unsaturated point, so a point clamped
// onto an edge never counts as a hit.
module segment_intersection #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // Fields from bit 0 up: a_start_x, a_start_y, a_end_x, a_end_y,
  // b_start_x, b_start_y, b_end_x, b_end_y.
  input  logic [8*COORD_WIDTH-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // Fields from bit 0 up: point_x, point_y, then zero fill.
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  // Fields from bit 0 up: lines_meet, hit.
  output logic [1:0]                  out_tuser
);
  import si_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int D     = W + 1;
  localparam int PW    = D + Q_W;
  localparam int NW    = D + Q_W + 1;
  localparam int CW    = NUM_COORDS * W;
  localparam int OUT_W = ((2 * W + 7) / 8) * 8;

  function automatic logic signed [W-1:0] crd_f(input logic [CW-1:0] v, input int idx);
    crd_f = $signed(v[idx*W +: W]);
  endfunction

  // The whole pipeline advances unless a finished result is waiting to be taken.
  logic en;
  logic res_vld;
  logic res_meet;
  logic res_hit;
  logic signed [W-1:0] res_px;
  logic signed [W-1:0] res_py;

  assign en        = !res_vld || out_tready;
  assign in_tready = en;

  // Input stage: register the coordinates and the differences that set up q.
  logic                s1_vld_r;
  logic [CW-1:0]       s1_crd_r;
  logic signed [D-1:0] s1_dx_r;
  logic signed [D-1:0] s1_dy_r;
  logic                s1_horiz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_crd_r   <= in_tdata;
      s1_dx_r    <= D'(crd_f(in_tdata, CI_A_END_X)) - D'(crd_f(in_tdata, CI_A_START_X));
      s1_dy_r    <= D'(crd_f(in_tdata, CI_A_START_Y)) - D'(crd_f(in_tdata, CI_A_END_Y));
      s1_horiz_r <= crd_f(in_tdata, CI_A_START_Y) == crd_f(in_tdata, CI_A_END_Y);
    end
  end

  // First divider: q = (x2 - x1) / (y1 - y2). A horizontal A leaves q unused.
  logic [D-1:0]        d1_num;
  logic [D-1:0]        d1_den;
  logic                d1_vld;
  logic signed [Q_W-1:0] d1_q;
  logic [CW:0]         d1_sb;

  assign d1_num = s1_dx_r[D-1] ? D'(0) - s1_dx_r : s1_dx_r;
  assign d1_den = s1_dy_r[D-1] ? D'(0) - s1_dy_r : s1_dy_r;

  si_div #(
    .NUM_W (D),
    .SB_W  (CW + 1)
  ) u_div_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_vld_r),
    .num_mag   (d1_num),
    .den_mag   (d1_den),
    .neg       (s1_dx_r[D-1] ^ s1_dy_r[D-1]),
    .in_sb     ({s1_horiz_r, s1_crd_r}),
    .out_valid (d1_vld),
    .quo       (d1_q),
    .out_sb    (d1_sb)
  );

  // Stage M1: the two products with q.
  logic                 m1_vld_r;
  logic [CW-1:0]        m1_crd_r;
  logic                 m1_horiz_r;
  logic signed [PW-1:0] m1_p1_r;
  logic signed [PW-1:0] m1_p2_r;
  logic signed [D-1:0]  dy34;
  logic signed [D-1:0]  dy31;

  assign dy34 = D'(crd_f(d1_sb[CW-1:0], CI_B_START_Y)) - D'(crd_f(d1_sb[CW-1:0], CI_B_END_Y));
  assign dy31 = D'(crd_f(d1_sb[CW-1:0], CI_B_START_Y)) - D'(crd_f(d1_sb[CW-1:0], CI_A_START_Y));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_crd_r   <= d1_sb[CW-1:0];
      m1_horiz_r <= d1_sb[CW];
      m1_p1_r    <= PW'(dy34) * PW'(d1_q);
      m1_p2_r    <= PW'(dy31) * PW'(d1_q);
    end
  end

  // Stage M2: pick the operands of n and decide whether the lines meet.
  logic                 m2_vld_r;
  logic [CW-1:0]        m2_crd_r;
  logic                 m2_meet_r;
  logic signed [NW-1:0] m2_num_r;
  logic signed [NW-1:0] m2_den_r;
  logic signed [NW-1:0] sn;
  logic signed [NW-1:0] fn;
  logic signed [NW-1:0] num_nxt;
  logic signed [NW-1:0] den_nxt;
  logic                 meet_nxt;
  logic signed [W-1:0]  bsy;
  logic signed [W-1:0]  bey;

  assign bsy = crd_f(m1_crd_r, CI_B_START_Y);
  assign bey = crd_f(m1_crd_r, CI_B_END_Y);
  assign sn  = (NW'(D'(crd_f(m1_crd_r, CI_B_START_X)) - D'(crd_f(m1_crd_r, CI_B_END_X)))
                <<< Q_FRAC) + NW'(m1_p1_r);
  assign fn  = (NW'(D'(crd_f(m1_crd_r, CI_B_START_X)) - D'(crd_f(m1_crd_r, CI_A_START_X)))
                <<< Q_FRAC) + NW'(m1_p2_r);

  always_comb begin
    if (m1_horiz_r) begin
      num_nxt  = NW'(D'(bsy) - D'(crd_f(m1_crd_r, CI_A_START_Y)));
      den_nxt  = NW'(D'(bsy) - D'(bey));
      meet_nxt = bsy != bey;
    end else begin
      num_nxt  = fn;
      den_nxt  = sn;
      meet_nxt = sn != NW'(0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (en) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_crd_r  <= m1_crd_r;
      m2_meet_r <= meet_nxt;
      m2_num_r  <= num_nxt;
      m2_den_r  <= den_nxt;
    end
  end

  // Second divider: the line parameter n along segment B.
  logic [NW-1:0]         d2_num;
  logic [NW-1:0]         d2_den;
  logic                  d2_vld;
  logic signed [Q_W-1:0] d2_n;
  logic [CW:0]           d2_sb;

  assign d2_num = m2_num_r[NW-1] ? NW'(0) - m2_num_r : m2_num_r;
  assign d2_den = m2_den_r[NW-1] ? NW'(0) - m2_den_r : m2_den_r;

  si_div #(
    .NUM_W (NW),
    .SB_W  (CW + 1)
  ) u_div_n (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (m2_vld_r),
    .num_mag   (d2_num),
    .den_mag   (d2_den),
    .neg       (m2_num_r[NW-1] ^ m2_den_r[NW-1]),
    .in_sb     ({m2_meet_r, m2_crd_r}),
    .out_valid (d2_vld),
    .quo       (d2_n),
    .out_sb    (d2_sb)
  );

  // Crossing point, extent test and the result register.
  si_point #(
    .COORD_WIDTH (W)
  ) u_point (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (d2_vld),
    .n_in       (d2_n),
    .meet_in    (d2_sb[CW]),
    .crd_in     (d2_sb[CW-1:0]),
    .out_valid  (res_vld),
    .lines_meet (res_meet),
    .hit        (res_hit),
    .point_x    (res_px),
    .point_y    (res_py)
  );

  assign out_tvalid = res_vld;
  assign out_tdata  = OUT_W'({res_py, res_px});
  assign out_tuser  = {res_hit, res_meet};

`include "segment_intersection_assert.svh"

  // Lines that do not meet carry an all-zero result.
  `SI_ASSERT_IMP(a_no_meet_zero, out_tvalid && !out_tuser[0], out_tdata == '0 && !out_tuser[1])
  // A hit is only possible where the lines meet.
  `SI_ASSERT_IMP(a_hit_meets, out_tvalid && out_tuser[1], out_tuser[0])
  // While a result waits, the pipeline holds and its inner valid bits do not move.
  `SI_ASSERT_NXT(a_stall_holds, out_tvalid && !out_tready, $stable(d2_vld) && $stable(m2_vld_r))

endmodule
